@@ rtl/aiwn_pkg.sv @@
// ----------------------------------------------------------------------------
// aiwn_pkg
// Shared constants, types and register indexes of the inverse affine warp.
// ----------------------------------------------------------------------------
package aiwn_pkg;

   // Frame store geometry and fixed-point format
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 512;
   localparam int FRAC_BITS  = 16;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

   // Field widths
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int COEF_W = 32;
   localparam int FW_W   = 11;
   localparam int FH_W   = 10;
   localparam int IDX_W  = 3;

   // Datapath widths: unsigned row/col as a signed multiplier operand
   localparam int OPND_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
   localparam int PROD_W  = COEF_W + OPND_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int COORD_W = ACC_W - FRAC_BITS;

   // Round half away from zero: add half, or half minus one below zero
   localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] RND_NEG = RND_POS - ACC_W'(1);

   // Register indexes
   localparam logic [IDX_W-1:0] REG_COL_PER_COL = 3'd0;
   localparam logic [IDX_W-1:0] REG_COL_PER_ROW = 3'd1;
   localparam logic [IDX_W-1:0] REG_COL_OFFSET  = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROW_PER_COL = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROW_PER_ROW = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROW_OFFSET  = 3'd5;
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 3'd6;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

   // Multiply step codes
   localparam logic [1:0] STEP_XC = 2'd0;  // col coefficient of x times col
   localparam logic [1:0] STEP_XR = 2'd1;  // row coefficient of x times row
   localparam logic [1:0] STEP_YC = 2'd2;  // col coefficient of y times col
   localparam logic [1:0] STEP_YR = 2'd3;  // row coefficient of y times row

   typedef struct packed {
      logic signed [COEF_W-1:0] col_per_col;
      logic signed [COEF_W-1:0] col_per_row;
      logic signed [COEF_W-1:0] col_offset;
      logic signed [COEF_W-1:0] row_per_col;
      logic signed [COEF_W-1:0] row_per_row;
      logic signed [COEF_W-1:0] row_offset;
      logic [FW_W-1:0]          frame_width;
      logic [FH_W-1:0]          frame_height;
   } cfg_type;

   typedef struct packed {
      logic       load_wr;   // write request pixel into the store
      logic       capture;   // latch produce coordinates and range error
      logic       mul_en;    // form one product
      logic [1:0] mul_step;  // which product
      logic       acc_init;  // load accumulators with the offsets
      logic       acc_en;    // add product into an accumulator
      logic       acc_y;     // accumulator select: 0 x, 1 y
      logic       round_en;  // round both accumulators
      logic       read_en;   // read the store, check bounds
      logic       resp_en;   // load the result registers
   } cmd_type;

   typedef struct packed {
      logic req_err;         // destination outside frame
   } status_type;

endpackage

@@ rtl/aiwn_csr.sv @@
// ----------------------------------------------------------------------------
// aiwn_csr
// Configuration register file: inverse matrix and frame size.
// ----------------------------------------------------------------------------
module aiwn_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [aiwn_pkg::IDX_W-1:0]   csr_index,
   input  logic [aiwn_pkg::COEF_W-1:0]  csr_write_data,
   output aiwn_pkg::cfg_type            cfg
);

   aiwn_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.col_per_col  <= aiwn_pkg::COEF_W'(1) << aiwn_pkg::FRAC_BITS;
         cfg_ff.col_per_row  <= '0;
         cfg_ff.col_offset   <= '0;
         cfg_ff.row_per_col  <= '0;
         cfg_ff.row_per_row  <= aiwn_pkg::COEF_W'(1) << aiwn_pkg::FRAC_BITS;
         cfg_ff.row_offset   <= '0;
         cfg_ff.frame_width  <= aiwn_pkg::FW_W'(640);
         cfg_ff.frame_height <= aiwn_pkg::FH_W'(480);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aiwn_pkg::REG_COL_PER_COL:  cfg_ff.col_per_col  <= csr_write_data;
            aiwn_pkg::REG_COL_PER_ROW:  cfg_ff.col_per_row  <= csr_write_data;
            aiwn_pkg::REG_COL_OFFSET:   cfg_ff.col_offset   <= csr_write_data;
            aiwn_pkg::REG_ROW_PER_COL:  cfg_ff.row_per_col  <= csr_write_data;
            aiwn_pkg::REG_ROW_PER_ROW:  cfg_ff.row_per_row  <= csr_write_data;
            aiwn_pkg::REG_ROW_OFFSET:   cfg_ff.row_offset   <= csr_write_data;
            aiwn_pkg::REG_FRAME_WIDTH:
               cfg_ff.frame_width  <= csr_write_data[aiwn_pkg::FW_W-1:0];
            aiwn_pkg::REG_FRAME_HEIGHT:
               cfg_ff.frame_height <= csr_write_data[aiwn_pkg::FH_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/aiwn_ctrl.sv @@
// ----------------------------------------------------------------------------
// aiwn_ctrl
// Sequencer: steps the shared multiplier, rounding, store read and result.
// ----------------------------------------------------------------------------
module aiwn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_mode,
   input  aiwn_pkg::status_type status,
   output logic                 busy,
   output aiwn_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_wr = accept && !req_mode;
            cmd.capture = accept && req_mode;
            step_in     = aiwn_pkg::STEP_XC;
            if (accept && req_mode) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = step_ff;
            cmd.acc_init = (step_ff == aiwn_pkg::STEP_XC);
            cmd.acc_en   = (step_ff != aiwn_pkg::STEP_XC);
            // product of the previous step lands here
            cmd.acc_y    = (step_ff == aiwn_pkg::STEP_YR);
            step_in      = step_ff + 2'd1;
            if (step_ff == aiwn_pkg::STEP_XC && status.req_err) begin
               step_in  = aiwn_pkg::STEP_XC;
               state_in = S_RESP;
            end else if (step_ff == aiwn_pkg::STEP_YR) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            cmd.acc_y  = 1'b1;
            state_in   = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            cmd.resp_en = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= aiwn_pkg::STEP_XC;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // a load never occupies the sequencer
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !req_mode |=> !busy)
      else $error("load transfer made the block busy");

   // the step count only runs inside the multiply phase
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_CALC |-> step_ff == aiwn_pkg::STEP_XC)
      else $error("multiply step count left running");

endmodule

@@ rtl/aiwn_dp.sv @@
// ----------------------------------------------------------------------------
// aiwn_dp
// Datapath: coordinate multiply-accumulate, rounding, frame store, result.
// ----------------------------------------------------------------------------
module aiwn_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  aiwn_pkg::cmd_type            cmd,
   input  aiwn_pkg::cfg_type            cfg,
   input  logic [aiwn_pkg::ROW_W-1:0]   req_pixel_row,
   input  logic [aiwn_pkg::COL_W-1:0]   req_pixel_col,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan0,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan1,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan2,
   output aiwn_pkg::status_type         status,
   output logic                         rsp_valid,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan0,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan1,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan2,
   output logic                         rsp_source_inside,
   output logic                         rsp_request_error
);

   localparam int CW = aiwn_pkg::CHAN_W;

   logic [aiwn_pkg::PIX_W-1:0]          store [aiwn_pkg::DEPTH];

   logic [aiwn_pkg::ROW_W-1:0]          row_ff;
   logic [aiwn_pkg::COL_W-1:0]          col_ff;
   logic                                err_ff;
   logic signed [aiwn_pkg::PROD_W-1:0]  prod_ff;
   logic signed [aiwn_pkg::ACC_W-1:0]   acc_x_ff, acc_y_ff;
   logic signed [aiwn_pkg::COORD_W-1:0] src_col_ff, src_row_ff;
   logic                                inside_ff;
   logic [aiwn_pkg::PIX_W-1:0]          rd_ff;
   logic                                rsp_valid_ff;
   logic [aiwn_pkg::PIX_W-1:0]          rsp_pix_ff;
   logic                                rsp_inside_ff, rsp_err_ff;

   logic [aiwn_pkg::FW_W-1:0]           w_eff;
   logic [aiwn_pkg::FH_W-1:0]           h_eff;
   logic signed [aiwn_pkg::COEF_W-1:0]  coef;
   logic signed [aiwn_pkg::OPND_W-1:0]  opnd;
   logic signed [aiwn_pkg::ACC_W-1:0]   sum_x, sum_y;
   logic                                in_frame;
   logic [aiwn_pkg::ADDR_W-1:0]         rd_addr;

   // frame size clipped to the store
   assign w_eff = (cfg.frame_width > aiwn_pkg::FW_W'(aiwn_pkg::MAX_WIDTH))
                ? aiwn_pkg::FW_W'(aiwn_pkg::MAX_WIDTH) : cfg.frame_width;
   assign h_eff = (cfg.frame_height > aiwn_pkg::FH_W'(aiwn_pkg::MAX_HEIGHT))
                ? aiwn_pkg::FH_W'(aiwn_pkg::MAX_HEIGHT) : cfg.frame_height;

   // frame store, row-major with a power-of-two pitch
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         store[{req_pixel_row, req_pixel_col}] <=
            {req_in_chan2, req_in_chan1, req_in_chan0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_pixel_row;
         col_ff <= req_pixel_col;
         err_ff <= (aiwn_pkg::FH_W'(req_pixel_row) >= h_eff)
                || (aiwn_pkg::FW_W'(req_pixel_col) >= w_eff);
      end
   end

   assign status.req_err = err_ff;

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_step)
         aiwn_pkg::STEP_XC: begin
            coef = cfg.col_per_col;
            opnd = $signed(aiwn_pkg::OPND_W'(col_ff));
         end
         aiwn_pkg::STEP_XR: begin
            coef = cfg.col_per_row;
            opnd = $signed(aiwn_pkg::OPND_W'(row_ff));
         end
         aiwn_pkg::STEP_YC: begin
            coef = cfg.row_per_col;
            opnd = $signed(aiwn_pkg::OPND_W'(col_ff));
         end
         default: begin
            coef = cfg.row_per_row;
            opnd = $signed(aiwn_pkg::OPND_W'(row_ff));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= coef * opnd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         acc_x_ff <= aiwn_pkg::ACC_W'(cfg.col_offset);
         acc_y_ff <= aiwn_pkg::ACC_W'(cfg.row_offset);
      end else if (cmd.acc_en) begin
         if (cmd.acc_y) begin
            acc_y_ff <= acc_y_ff + aiwn_pkg::ACC_W'(prod_ff);
         end else begin
            acc_x_ff <= acc_x_ff + aiwn_pkg::ACC_W'(prod_ff);
         end
      end
   end

   // half away from zero: (v + half - sign) >>> frac
   assign sum_x = acc_x_ff + (acc_x_ff[aiwn_pkg::ACC_W-1]
                ? aiwn_pkg::RND_NEG : aiwn_pkg::RND_POS);
   assign sum_y = acc_y_ff + (acc_y_ff[aiwn_pkg::ACC_W-1]
                ? aiwn_pkg::RND_NEG : aiwn_pkg::RND_POS);

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         src_col_ff <= aiwn_pkg::COORD_W'(sum_x >>> aiwn_pkg::FRAC_BITS);
         src_row_ff <= aiwn_pkg::COORD_W'(sum_y >>> aiwn_pkg::FRAC_BITS);
      end
   end

   assign in_frame =
      !src_col_ff[aiwn_pkg::COORD_W-1] && !src_row_ff[aiwn_pkg::COORD_W-1]
      && ($unsigned(src_col_ff) < aiwn_pkg::COORD_W'(w_eff))
      && ($unsigned(src_row_ff) < aiwn_pkg::COORD_W'(h_eff));

   // address is only meaningful when in_frame; otherwise the data is dropped
   assign rd_addr = {src_row_ff[aiwn_pkg::ROW_W-1:0], src_col_ff[aiwn_pkg::COL_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_ff     <= store[rd_addr];
         inside_ff <= in_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.resp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_en) begin
         rsp_inside_ff <= inside_ff && !err_ff;
         rsp_err_ff    <= err_ff;
         rsp_pix_ff    <= (inside_ff && !err_ff) ? rd_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_chan0     = rsp_pix_ff[CW-1:0];
   assign rsp_out_chan1     = rsp_pix_ff[2*CW-1:CW];
   assign rsp_out_chan2     = rsp_pix_ff[3*CW-1:2*CW];
   assign rsp_source_inside = rsp_inside_ff;
   assign rsp_request_error = rsp_err_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_source_inside && rsp_request_error))
      else $error("result both inside and in error");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_source_inside |-> rsp_pix_ff == '0)
      else $error("pixel outside frame not zeroed");

endmodule

@@ rtl/affine_inverse_warp_nearest.sv @@
// ----------------------------------------------------------------------------
// affine_inverse_warp_nearest
// Backward affine warp of a three-channel frame, nearest-neighbor sampling.
// ----------------------------------------------------------------------------
//
// Channel   Handshake               Payload
// req       start / busy            req_mode, req_pixel_row, req_pixel_col,
//                                   req_in_chan0..2
// rsp       rsp_valid (strobe)      rsp_out_chan0..2, rsp_source_inside,
//                                   rsp_request_error
// csr       csr_write_enable        csr_index, csr_write_data
//
// Load transfer: written straight into the frame store; busy stays
//   low, so loads may come every cycle when the block is not busy.
// Produce transfer: busy through four products on one shared 32x11
//   multiplier, one trailing add, rounding, store read and result load;
//   the strobe follows, when the next transfer can be taken.
// Destination outside the frame: only the first product and the result load.
// Reset: synchronous; clears the sequencer and the strobe and sets the
//   configuration registers to their defaults. The frame store is not
//   cleared and holds nothing until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module affine_inverse_warp_nearest (
   input  logic                         clock,
   input  logic                         reset,

   // item transfer
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_mode,
   input  logic [aiwn_pkg::ROW_W-1:0]   req_pixel_row,
   input  logic [aiwn_pkg::COL_W-1:0]   req_pixel_col,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan0,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan1,
   input  logic [aiwn_pkg::CHAN_W-1:0]  req_in_chan2,

   // result transfer
   output logic                         rsp_valid,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan0,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan1,
   output logic [aiwn_pkg::CHAN_W-1:0]  rsp_out_chan2,
   output logic                         rsp_source_inside,
   output logic                         rsp_request_error,

   // configuration writes
   input  logic                         csr_write_enable,
   input  logic [aiwn_pkg::IDX_W-1:0]   csr_index,
   input  logic [aiwn_pkg::COEF_W-1:0]  csr_write_data
);

   aiwn_pkg::cfg_type    cfg;     // live matrix and frame size
   aiwn_pkg::cmd_type    cmd;     // sequencer to datapath
   aiwn_pkg::status_type status;  // datapath to sequencer

   // register file
   aiwn_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // sequencer: decodes load vs produce, walks the multiply steps
   aiwn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // datapath: MAC, rounding, bounds check, frame store, result registers
   aiwn_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_pixel_row     (req_pixel_row),
      .req_pixel_col     (req_pixel_col),
      .req_in_chan0      (req_in_chan0),
      .req_in_chan1      (req_in_chan1),
      .req_in_chan2      (req_in_chan2),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_out_chan0     (rsp_out_chan0),
      .rsp_out_chan1     (rsp_out_chan1),
      .rsp_out_chan2     (rsp_out_chan2),
      .rsp_source_inside (rsp_source_inside),
      .rsp_request_error (rsp_request_error)
   );

endmodule
